### rtl/core/hsi_pkg.sv
// Shared types and constants for the HSI to RGB converter.
`default_nettype none

package hsi_pkg;

  localparam int FracBits = 12;
  localparam int HueW = 12;
  localparam int SatW = 13;
  localparam int IntW = 13;
  localparam int ChanW = 8;

  // Ratio is signed Q2.F; the trailing weight (one minus ratio) needs one more bit.
  localparam int RatioW = FracBits + 3;
  localparam int WeightW = RatioW + 1;
  localparam int SkW = SatW + 1 + WeightW;
  localparam int InnerW = SkW + 1;
  localparam int PosW = SkW;
  localparam int I255W = IntW + ChanW;
  localparam int ProdW = I255W + PosW;
  localparam int ScaleShift = 3 * FracBits;
  localparam int ChanMax = 255;

  localparam logic signed [WeightW-1:0] UnitWeight = WeightW'(1) << FracBits;
  localparam logic signed [InnerW-1:0] InnerBias = InnerW'(1) << (2 * FracBits);

  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCountW = $clog2(QueueDepth + 1);

  localparam int NumLanes = 3;
  localparam int LaneLead = 0;
  localparam int LaneTrail = 1;
  localparam int LaneRem = 2;

  // Q28 constants for building the ratio table.
  localparam longint Q28One = 64'sd268435456;
  localparam longint PiThirdQ28 = 64'sd281104952;
  localparam longint TwoPiThirdQ28 = 64'sd562209904;
  localparam int TaylorTerms = 14;
  localparam longint TaylorDiv [TaylorTerms] = '{
    64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132, 64'sd182,
    64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552, 64'sd650, 64'sd756
  };

  typedef enum logic [1:0] {
    SectorZero = 2'd0,
    SectorOne = 2'd1,
    SectorTwo = 2'd2
  } sector_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [IntW-1:0] intensity;
  } hsi_pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    sector_t sector;
    logic [SatW-1:0] saturation;
    logic [IntW-1:0] intensity;
    logic signed [RatioW-1:0] ratio;
  } hsi_work_t;

endpackage

`default_nettype wire

### rtl/core/hsi_ratio_rom.sv
// Synchronous ROM of cos(t)/cos(60deg-t) in signed Q2.12, built at elaboration.
`default_nettype none

module hsi_ratio_rom import hsi_pkg::*; #(
  parameter int RATIO_TABLE_DEPTH = 4096,
  parameter int AddrW = $clog2(RATIO_TABLE_DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [AddrW-1:0]         addr,
  output logic signed [RatioW-1:0]      data
);

  function automatic longint cos_q28(input longint angle);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x = (angle < 0) ? -angle : angle;
    x2 = (x * x) / Q28One;
    term = Q28One;
    sum = Q28One;
    for (int n = 0; n < TaylorTerms; n++) begin
      term = -((term * x2) / Q28One) / TaylorDiv[n];
      sum = sum + term;
    end
    return sum;
  endfunction

  // Restoring division, one quotient bit per step.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint ratio_entry(input longint k);
    longint t;
    longint num;
    longint den;
    longint unsigned mag;
    longint unsigned q;
    t = (k * TwoPiThirdQ28) / RATIO_TABLE_DEPTH;
    num = cos_q28(t);
    den = cos_q28(PiThirdQ28 - t);
    mag = longint'((num < 0) ? -num : num) << FracBits;
    q = udiv(2 * mag + longint'(den), 2 * longint'(den));
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  logic signed [RatioW-1:0] table_rom [RATIO_TABLE_DEPTH];

  for (genvar k = 0; k < RATIO_TABLE_DEPTH; k++) begin : g_entry
    localparam logic signed [RatioW-1:0] Entry = RatioW'(ratio_entry(longint'(k)));
    assign table_rom[k] = Entry;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= table_rom[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsi_front.sv
// Front end: accepts pixels, splits hue into sector and angle, looks up the ratio.
`default_nettype none

module hsi_front import hsi_pkg::*; #(
  parameter int RATIO_TABLE_DEPTH = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hsi_pixel_t pixel,
  input  wire logic       pixel_valid,
  output logic            pixel_stall,
  output hsi_work_t       work,
  output logic            work_valid,
  input  wire logic       queue_full
);

  localparam int AddrW = $clog2(RATIO_TABLE_DEPTH);
  localparam int DepthW = $clog2(RATIO_TABLE_DEPTH + 1);
  localparam int ScaledW = FracBits + DepthW;

  logic              advance;
  logic [HueW+1:0]   hue3;
  logic [ScaledW-1:0] scaled;
  logic [AddrW-1:0]  rom_addr;
  logic signed [RatioW-1:0] rom_data;

  logic              hold_valid;
  sector_t           hold_sector;
  logic [SatW-1:0]   hold_sat;
  logic [IntW-1:0]   hold_int;

  // The held transaction leaves whenever the queue has room.
  assign pixel_stall = hold_valid && queue_full;
  assign advance = !pixel_stall;

  assign hue3 = {2'b00, pixel.hue} + {1'b0, pixel.hue, 1'b0};
  assign scaled = ScaledW'(hue3[FracBits-1:0]) * ScaledW'(RATIO_TABLE_DEPTH);
  assign rom_addr = scaled[FracBits +: AddrW];

  hsi_ratio_rom #(
    .RATIO_TABLE_DEPTH(RATIO_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .en  (advance),
    .addr(rom_addr),
    .data(rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (advance) begin
      hold_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hold_sector <= sector_t'(hue3[HueW+1:HueW]);
      hold_sat <= pixel.saturation;
      hold_int <= pixel.intensity;
    end
  end

  assign work_valid = hold_valid;
  assign work = '{sector: hold_sector, saturation: hold_sat, intensity: hold_int,
                  ratio: rom_data};

endmodule

`default_nettype wire

### rtl/core/hsi_queue.sv
// Small FIFO that decouples the front end from the arithmetic back end.
`default_nettype none

module hsi_queue import hsi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire hsi_work_t work,
  input  wire logic      work_valid,
  output logic           full,
  output hsi_work_t      head,
  output logic           head_valid,
  input  wire logic      pop
);

  hsi_work_t              entries [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCountW-1:0] count;
  logic                   push;

  assign full = (count == QueueCountW'(QueueDepth));
  assign push = work_valid && !full;
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + QueueCountW'(push) - QueueCountW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= work;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QueueCountW'(QueueDepth))
    else $error("queue count exceeds its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == $past(count) + QueueCountW'($past(push)) - QueueCountW'($past(pop)))
    else $error("queue count lost a transaction");

endmodule

`default_nettype wire

### rtl/core/hsi_back.sv
// Back end: three channel products, scaling, clamping and sector routing.
`default_nettype none

module hsi_back import hsi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire hsi_work_t head,
  input  wire logic      head_valid,
  output logic           pop,
  output rgb_pixel_t     rgb,
  output logic           rgb_valid,
  input  wire logic      rgb_stall
);

  logic en;

  logic signed [WeightW-1:0] weight [NumLanes];
  logic signed [SkW-1:0]     sk     [NumLanes];
  logic signed [InnerW-1:0]  inner  [NumLanes];
  logic [PosW-1:0]           pos    [NumLanes];

  logic              v1;
  sector_t           sector1;
  logic [I255W-1:0]  i255_1;
  logic [PosW-1:0]   pos1 [NumLanes];

  logic              v2;
  sector_t           sector2;
  logic [ProdW-1:0]  prod2 [NumLanes];

  logic [ChanW-1:0]  chan [NumLanes];

  // The whole back pipeline moves unless a finished pixel is held at the output.
  assign en = !(rgb_valid && rgb_stall);
  assign pop = en && head_valid;

  assign weight[LaneLead] = WeightW'(head.ratio);
  assign weight[LaneTrail] = UnitWeight - WeightW'(head.ratio);
  assign weight[LaneRem] = -UnitWeight;

  // A nonpositive inner term gives a zero channel.
  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      sk[c] = $signed({1'b0, head.saturation}) * weight[c];
      inner[c] = $signed({sk[c][SkW-1], sk[c]}) + InnerBias;
      pos[c] = (!inner[c][InnerW-1] && inner[c] != '0) ? inner[c][PosW-1:0] : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      chan[c] = (prod2[c][ProdW-1:ScaleShift] > (ProdW - ScaleShift)'(ChanMax))
              ? ChanW'(ChanMax) : prod2[c][ScaleShift +: ChanW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
      rgb_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector1 <= head.sector;
      i255_1 <= I255W'(head.intensity) * I255W'(ChanMax);
      pos1 <= pos;
      sector2 <= sector1;
      for (int c = 0; c < NumLanes; c++) begin
        prod2[c] <= ProdW'(i255_1) * ProdW'(pos1[c]);
      end
      unique case (sector2)
        SectorZero: begin
          rgb <= '{red: chan[LaneLead], green: chan[LaneTrail], blue: chan[LaneRem]};
        end
        SectorOne: begin
          rgb <= '{red: chan[LaneRem], green: chan[LaneLead], blue: chan[LaneTrail]};
        end
        default: begin
          rgb <= '{red: chan[LaneTrail], green: chan[LaneRem], blue: chan[LaneLead]};
        end
      endcase
    end
  end

  a_pop_only_when_moving: assert property (@(posedge clk) disable iff (rst)
    pop |-> en && head_valid)
    else $error("back end popped while stalled");

  a_stall_holds_stages: assert property (@(posedge clk) disable iff (rst)
    !en |=> v1 == $past(v1) && v2 == $past(v2))
    else $error("back stages moved under output stall");

  a_valid_flows: assert property (@(posedge clk) disable iff (rst)
    en && v2 |=> rgb_valid)
    else $error("pixel dropped between product and output stage");

endmodule

`default_nettype wire

### rtl/core/hsi_to_rgb_converter.sv
// A pixel passes the front hold register, the queue and the back stage registers.
// Throughput: one pixel per clock unless stalled; the ratio ROM read and three
// 21x30 multiplies pipelined; a 4-entry queue separates lookup from arithmetic.
// The ratio ROM is constant and is built at elaboration; it needs no fill pass.
// Reset (synchronous, active high) empties the queue and clears all valid flags.
`default_nettype none

module hsi_to_rgb_converter import hsi_pkg::*; #(
  parameter int RATIO_TABLE_DEPTH = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hsi_pixel_t pixel,
  input  wire logic       pixel_valid,
  output logic            pixel_stall,
  output rgb_pixel_t      rgb,
  output logic            rgb_valid,
  input  wire logic       rgb_stall
);

  hsi_work_t work;
  logic      work_valid;
  logic      queue_full;
  hsi_work_t head;
  logic      head_valid;
  logic      pop;

  hsi_front #(
    .RATIO_TABLE_DEPTH(RATIO_TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .work       (work),
    .work_valid (work_valid),
    .queue_full (queue_full)
  );

  hsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .work      (work),
    .work_valid(work_valid),
    .full      (queue_full),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  hsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .rgb       (rgb),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall)
  );

endmodule

`default_nettype wire
